// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, reset included.
`define RPDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only while reset is released.
`define RPDC_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== src/rpdc_pkg.sv =====
package rpdc_pkg;

  // Register indexes on the write port
  localparam logic [2:0] CFG_RIGHT_BOUND    = 3'd0;
  localparam logic [2:0] CFG_LEFT_BOUND     = 3'd1;
  localparam logic [2:0] CFG_BASE_SPEED     = 3'd2;
  localparam logic [2:0] CFG_CHANGE_PERIOD  = 3'd3;
  localparam logic [2:0] CFG_KEEP_THRESHOLD = 3'd4;
  localparam logic [2:0] CFG_FAST_SPEED     = 3'd5;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 40;

  // Reset values of the registers
  localparam logic signed [31:0] RIGHT_BOUND_RST    = -32'sd100000;
  localparam logic signed [31:0] LEFT_BOUND_RST     = 32'sd100000;
  localparam logic [13:0]        BASE_SPEED_RST     = 14'd4500;
  localparam logic [15:0]        CHANGE_PERIOD_RST  = 16'd500;
  localparam logic [6:0]         KEEP_THRESHOLD_RST = 7'd10;
  localparam logic [13:0]        FAST_SPEED_RST     = 14'd1500;

  // Fixed tuning
  localparam logic signed [32:0] RAIL_MARGIN  = 33'sd30000;
  localparam logic [15:0]        STAY_LIMIT   = 16'd1000;
  localparam logic [9:0]         BUF_LOW      = 10'd50;
  localparam logic [9:0]         BUF_HIGH     = 10'd150;
  localparam logic [16:0]        ARRIVE_SPEED = 17'd1500;
  localparam logic [17:0]        ARRIVE_SLACK = 18'd200;
  localparam logic [15:0]        ARRIVE_LIMIT = 16'd150;
  localparam logic [17:0]        SLOW_SLACK   = 18'd2000;
  localparam logic [15:0]        SLOW_LIMIT   = 16'd80;
  localparam logic [15:0]        CNT_MAX      = 16'hFFFF;
  // 52429 = (2^18 + 1) / 5, exact floor(y/5) for y below 2^18
  localparam logic [15:0]        RECIP_5      = 16'd52429;

  typedef struct packed {
    logic signed [31:0] right_bound;
    logic signed [31:0] left_bound;
    logic [13:0]        base_speed;
    logic [15:0]        change_period;
    logic [6:0]         keep_threshold;
    logic [13:0]        fast_speed;
  } cfg_t;

  typedef struct packed {
    logic [9:0]         buffer_level;
    logic [15:0]        area_stay_ticks;
    logic [6:0]         random_draw;
    logic               left_sensor_hit;
    logic               right_sensor_hit;
    logic signed [31:0] position;
    logic signed [15:0] measured_speed;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        reversal_count;
    logic               power_limited;
    logic               hold_flag;
    logic signed [15:0] target_speed;
  } out_item_t;

  // floor(b * 13 / 20): drop two bits, then divide by 5 through the reciprocal
  function automatic logic [13:0] scale_13_20(input logic [13:0] b);
    logic [17:0] x;
    logic [31:0] p;
    x = 18'(b) * 18'd13;
    p = 32'(x[17:2]) * 32'(RECIP_5);
    return p[31:18];
  endfunction

  function automatic logic [16:0] abs16(input logic signed [15:0] v);
    logic [16:0] e;
    e = {v[15], v};
    return v[15] ? (~e + 17'd1) : e;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    return (c == CNT_MAX) ? c : c + 16'd1;
  endfunction

endpackage

// ===== src/random_patrol_direction_control_top.sv =====
// Channel | Role       | Width | Transfer
// in_     | slave      | 88    | in_tvalid & in_tready, one control tick
// out_    | master     | 40    | out_tvalid & out_tready, one speed command per tick
// cfg_    | write port | 32    | cfg_we high, cfg_addr picks the register
//
// An input transfer is registered in the input register, then moves into the result register
// when that register is free or draining; out_tvalid is the result register's valid flag. One
// item per cycle is sustained while out_tready stays high.
// The patrol state updates in the cycle an item moves from the input register into the
// result register, so the next item in the input register already sees it.
// rst_n is synchronous: it clears both valid flags and the patrol state and resets the configuration registers.
// A stalled out_ holds its result; in_tready drops only while both registers are full
// and out_tready is low.
module random_patrol_direction_control_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // measured_speed[15:0], position[47:16], right_sensor_hit[48],
  // left_sensor_hit[49], random_draw[56:50], area_stay_ticks[72:57],
  // buffer_level[82:73], zero fill [87:83]
  input  logic [rpdc_pkg::IN_DATA_W-1:0]      in_tdata,
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // target_speed[15:0], hold_flag[16], power_limited[17],
  // reversal_count[33:18], zero fill [39:34]
  output logic [rpdc_pkg::OUT_DATA_W-1:0]     out_tdata,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [rpdc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [rpdc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  rpdc_pkg::cfg_t      cfg;
  rpdc_pkg::in_item_t  in_item_r;
  rpdc_pkg::out_item_t res;
  rpdc_pkg::out_item_t out_item_r;

  logic in_v_r;
  logic out_v_r;
  logic advance;   // input register hands its item to the result register

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  rpdc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rpdc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .cfg   (cfg),
    .item  (in_item_r),
    .res   (res)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready)
        in_v_r <= in_tvalid;
      if (advance)
        out_v_r <= 1'b1;
      else if (out_tready)
        out_v_r <= 1'b0;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready)
      in_item_r <= in_tdata[$bits(rpdc_pkg::in_item_t)-1:0];
    if (advance)
      out_item_r <= res;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(rpdc_pkg::OUT_DATA_W - $bits(rpdc_pkg::out_item_t)){1'b0}},
                       out_item_r};

endmodule

// ===== src/rpdc_cfg.sv =====
module rpdc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rpdc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [rpdc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output rpdc_pkg::cfg_t                   cfg
);

  rpdc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.right_bound    <= rpdc_pkg::RIGHT_BOUND_RST;
      cfg_r.left_bound     <= rpdc_pkg::LEFT_BOUND_RST;
      cfg_r.base_speed     <= rpdc_pkg::BASE_SPEED_RST;
      cfg_r.change_period  <= rpdc_pkg::CHANGE_PERIOD_RST;
      cfg_r.keep_threshold <= rpdc_pkg::KEEP_THRESHOLD_RST;
      cfg_r.fast_speed     <= rpdc_pkg::FAST_SPEED_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        rpdc_pkg::CFG_RIGHT_BOUND:    cfg_r.right_bound    <= signed'(cfg_wdata);
        rpdc_pkg::CFG_LEFT_BOUND:     cfg_r.left_bound     <= signed'(cfg_wdata);
        rpdc_pkg::CFG_BASE_SPEED:     cfg_r.base_speed     <= cfg_wdata[13:0];
        rpdc_pkg::CFG_CHANGE_PERIOD:  cfg_r.change_period  <= cfg_wdata[15:0];
        rpdc_pkg::CFG_KEEP_THRESHOLD: cfg_r.keep_threshold <= cfg_wdata[6:0];
        rpdc_pkg::CFG_FAST_SPEED:     cfg_r.fast_speed     <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/rpdc_core.sv =====
module rpdc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  rpdc_pkg::cfg_t       cfg,
  input  rpdc_pkg::in_item_t   item,
  output rpdc_pkg::out_item_t  res
);

  logic signed [15:0] tgt_r, tgt_nxt;
  logic [15:0]        ftc_r, ftc_nxt;
  logic [15:0]        asc_r, asc_nxt;
  logic [15:0]        sc_r, sc_nxt;
  logic [15:0]        rev_r, rev_nxt;
  logic               lim_r, lim_nxt;
  logic               hold_r, hold_nxt;

  logic [13:0]        mag_scaled, mag_old, mag_new;
  logic [16:0]        ameas, atgt;
  logic signed [15:0] t1, t2;
  logic signed [32:0] pos_x, rb_lim, lb_lim;
  logic [15:0]        ftc1, ftc2, asc2;
  logic               hold2, stay_clr, rend, lend, decide;

  always_comb begin
    mag_scaled = rpdc_pkg::scale_13_20(cfg.base_speed);
    mag_old    = lim_r ? mag_scaled : cfg.base_speed;
    ameas      = rpdc_pkg::abs16(item.measured_speed);

    // magnitude check with the old flag
    t1 = tgt_r;
    if (rpdc_pkg::abs16(tgt_r) != {3'b000, mag_old})
      t1 = signed'({2'b00, mag_old});

    ftc1 = (ameas > {3'b000, cfg.fast_speed}) ? rpdc_pkg::sat_inc(ftc_r) : ftc_r;

    stay_clr = item.area_stay_ticks > rpdc_pkg::STAY_LIMIT;
    ftc2  = stay_clr ? 16'd0 : ftc1;
    asc2  = stay_clr ? 16'd0 : asc_r;
    hold2 = stay_clr ? 1'b0 : hold_r;

    // power-buffer hysteresis
    lim_nxt = lim_r | (item.buffer_level < rpdc_pkg::BUF_LOW);
    if (lim_nxt && (item.buffer_level > rpdc_pkg::BUF_HIGH))
      lim_nxt = 1'b0;
    mag_new = lim_nxt ? mag_scaled : cfg.base_speed;

    // rail ends, left wins when both fire
    pos_x  = {item.position[31], item.position};
    rb_lim = {cfg.right_bound[31], cfg.right_bound} + rpdc_pkg::RAIL_MARGIN;
    lb_lim = {cfg.left_bound[31], cfg.left_bound} - rpdc_pkg::RAIL_MARGIN;
    rend   = item.right_sensor_hit && (pos_x < rb_lim);
    lend   = item.left_sensor_hit && (pos_x > lb_lim);
    if (lend)
      t2 = -signed'({2'b00, mag_new});
    else if (rend)
      t2 = signed'({2'b00, mag_new});
    else
      t2 = t1;
    ftc_nxt = (rend || lend) ? 16'd0 : ftc2;

    // random reversal decision
    tgt_nxt  = t2;
    hold_nxt = hold2;
    rev_nxt  = rev_r;
    decide   = ftc_nxt == cfg.change_period;
    if (decide) begin
      if (item.random_draw >= cfg.keep_threshold) begin
        tgt_nxt  = -t2;
        hold_nxt = 1'b0;
        rev_nxt  = rev_r + 16'd1;
      end
      ftc_nxt = 16'd0;
    end

    // arrive and slow pacing
    atgt    = rpdc_pkg::abs16(tgt_nxt);
    asc_nxt = asc2;
    if ((atgt > rpdc_pkg::ARRIVE_SPEED) &&
        (({1'b0, ameas} + rpdc_pkg::ARRIVE_SLACK) > {1'b0, atgt}))
      asc_nxt = rpdc_pkg::sat_inc(asc2);

    sc_nxt = sc_r;
    if (asc_nxt > rpdc_pkg::ARRIVE_LIMIT) begin
      if (({1'b0, ameas} + rpdc_pkg::SLOW_SLACK) < {1'b0, atgt})
        sc_nxt = rpdc_pkg::sat_inc(sc_r);
      hold_nxt = 1'b1;
      if (sc_nxt > rpdc_pkg::SLOW_LIMIT) begin
        asc_nxt  = 16'd0;
        sc_nxt   = 16'd0;
        hold_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r  <= '0;
      ftc_r  <= '0;
      asc_r  <= '0;
      sc_r   <= '0;
      rev_r  <= '0;
      lim_r  <= 1'b0;
      hold_r <= 1'b0;
    end else if (step) begin
      tgt_r  <= tgt_nxt;
      ftc_r  <= ftc_nxt;
      asc_r  <= asc_nxt;
      sc_r   <= sc_nxt;
      rev_r  <= rev_nxt;
      lim_r  <= lim_nxt;
      hold_r <= hold_nxt;
    end
  end

  assign res.target_speed   = tgt_nxt;
  assign res.hold_flag      = hold_nxt;
  assign res.power_limited  = lim_nxt;
  assign res.reversal_count = rev_nxt;

endmodule

// ===== src/rpdc_checker.sv =====
`include "assert_macros.svh"

module rpdc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rpdc_pkg::OUT_DATA_W-1:0] out_tdata
);

  // a stalled result holds
  `RPDC_ASSERT_RUN(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // reset empties the result register
  `RPDC_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "result valid right after reset")

  // the input side never stalls while the result register can drain
  `RPDC_ASSERT_ALWAYS(a_no_bubble, (out_tready || !out_tvalid) |-> in_tready, "input stalled with free output")

  // an accepted item passes the input register and the result register, and a result is then valid
  `RPDC_ASSERT_RUN(a_latency, in_tvalid && in_tready |-> ##2 out_tvalid, "accepted item produced no result")

  // target magnitude never reaches the most negative code
  `RPDC_ASSERT_RUN(a_tgt_range, out_tvalid |-> out_tdata[15:0] != 16'h8000, "target speed out of range")

endmodule

bind random_patrol_direction_control_top rpdc_checker u_rpdc_checker (.*);
